[hdl/rav_pkg.sv]
package rav_pkg;

  // extra fraction bits carried through the rotation
  localparam int GUARD = 8;
  // angle word: radians in Q30, signed
  localparam int ZW = 32;
  localparam int ANG_FRAC = 30;

  // pi in Q60 and radians per (1/128 degree * 1/180) scale: pi / 23040
  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [47:0] RAD_PER_UNIT = 48'(PI_Q60 / 64'd23040);

  // inverse of the CORDIC gain limit, Q30
  localparam logic [29:0] INV_K_Q30 = 30'd652032874;

  typedef logic signed [ZW-1:0] angle_t;

  // largest residual angle after quarter-turn removal, with one LSB margin
  localparam angle_t Z_MAX = 32'sd843314858;

  // round(atan(2^-i) * 2^30)
  function automatic angle_t atan_q30(input logic [4:0] idx);
    angle_t a;
    case (idx)
      5'd0:    a = 32'sd843314857;
      5'd1:    a = 32'sd497837829;
      5'd2:    a = 32'sd263043837;
      5'd3:    a = 32'sd133525159;
      5'd4:    a = 32'sd67021687;
      5'd5:    a = 32'sd33543516;
      5'd6:    a = 32'sd16775851;
      5'd7:    a = 32'sd8388437;
      5'd8:    a = 32'sd4194283;
      5'd9:    a = 32'sd2097149;
      5'd10:   a = 32'sd1048576;
      5'd11:   a = 32'sd524288;
      5'd12:   a = 32'sd262144;
      5'd13:   a = 32'sd131072;
      5'd14:   a = 32'sd65536;
      5'd15:   a = 32'sd32768;
      5'd16:   a = 32'sd16384;
      5'd17:   a = 32'sd8192;
      5'd18:   a = 32'sd4096;
      5'd19:   a = 32'sd2048;
      5'd20:   a = 32'sd1024;
      5'd21:   a = 32'sd512;
      5'd22:   a = 32'sd256;
      5'd23:   a = 32'sd128;
      5'd24:   a = 32'sd64;
      5'd25:   a = 32'sd32;
      5'd26:   a = 32'sd16;
      5'd27:   a = 32'sd8;
      5'd28:   a = 32'sd4;
      5'd29:   a = 32'sd2;
      5'd30:   a = 32'sd1;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

[hdl/random_angle_vector_rotation_2d.sv]
// Random-angle rotation of a 2D velocity, for angular noise in a flocking step.
// Input channel (in_valid/in_ready): velocity in_vel_x, in_vel_y (signed Q2.21)
// and a uniform fraction in_rand_u. The angle is (rand_u - 1/2) times the noise
// span; whole quarter turns are applied exactly, the rest by CORDIC stages with
// gain compensation. Output channel (out_valid/out_ready): rot_x, rot_y,
// saturated to the velocity range. One result per input, in order.
// Throughput: one item per cycle. Every stage is a register in one chain, so
// an item enters each cycle the output register is empty or being taken.
// Stages: CORDIC_STAGES + 7 register stages from the input transfer to the
// output register (4 angle-prep stages, one per CORDIC stage, 3 for gain and
// saturation).
// Stall: while out_valid is high and out_ready low, the whole chain holds and
// in_ready is low; nothing is dropped or repeated.
// Reset (rst_n, synchronous): clears all valid bits and sets noise_span to 0.
// Config: APB register 0 (byte address 0) is noise_span in 1/128 degree; write
// it only while no item is in flight.
module random_angle_vector_rotation_2d #(
  parameter int VEL_BITS      = 24,
  parameter int RAND_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [VEL_BITS-1:0] in_vel_x,
  input  logic signed [VEL_BITS-1:0] in_vel_y,
  input  logic [RAND_BITS-1:0]       in_rand_u,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [VEL_BITS-1:0] out_rot_x,
  output logic signed [VEL_BITS-1:0] out_rot_y
);
  import rav_pkg::*;

  localparam int XW = VEL_BITS + GUARD + 3;
  localparam logic ADDR_NOISE_SPAN = 1'b0;

  logic        en;
  logic        cfg_wr;
  logic [15:0] span_r;

  // chain advances unless a result waits at the output
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_NOISE_SPAN);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= '0;
    end else if (cfg_wr) begin
      span_r <= pwdata[15:0];
    end
  end

  assign prdata = (paddr[2] == ADDR_NOISE_SPAN) ? {16'd0, span_r} : 32'd0;

  // angle prep and quarter turns
  logic                 cv [CORDIC_STAGES+1];
  logic signed [XW-1:0] cx [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy [CORDIC_STAGES+1];
  angle_t               cz [CORDIC_STAGES+1];

  rav_prep #(
    .VEL_BITS  (VEL_BITS),
    .RAND_BITS (RAND_BITS)
  ) u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .span      (span_r),
    .in_valid  (in_valid),
    .vel_x     (in_vel_x),
    .vel_y     (in_vel_y),
    .rand_u    (in_rand_u),
    .out_valid (cv[0]),
    .x_o       (cx[0]),
    .y_o       (cy[0]),
    .z_o       (cz[0])
  );

  // CORDIC rotation stages
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    rav_cordic_stage #(
      .VEL_BITS (VEL_BITS),
      .SHIFT    (i)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (cv[i]),
      .x_i       (cx[i]),
      .y_i       (cy[i]),
      .z_i       (cz[i]),
      .out_valid (cv[i+1]),
      .x_o       (cx[i+1]),
      .y_o       (cy[i+1]),
      .z_o       (cz[i+1])
    );
  end

  // gain compensation, saturation, output register
  rav_gain #(
    .VEL_BITS (VEL_BITS)
  ) u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cv[CORDIC_STAGES]),
    .x_i       (cx[CORDIC_STAGES]),
    .y_i       (cy[CORDIC_STAGES]),
    .out_valid (out_valid),
    .rot_x     (out_rot_x),
    .rot_y     (out_rot_y)
  );

`ifndef SYNTHESIS
  a_span_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> $stable(span_r))
    else $error("noise span changed without a register write");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid set right after reset");
`endif

endmodule

[hdl/rav_prep.sv]
module rav_prep #(
  parameter int VEL_BITS  = 24,
  parameter int RAND_BITS = 16,
  localparam int XW = VEL_BITS + rav_pkg::GUARD + 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic [15:0]                span,
  input  logic                       in_valid,
  input  logic signed [VEL_BITS-1:0] vel_x,
  input  logic signed [VEL_BITS-1:0] vel_y,
  input  logic [RAND_BITS-1:0]       rand_u,
  output logic                       out_valid,
  output logic signed [XW-1:0]       x_o,
  output logic signed [XW-1:0]       y_o,
  output rav_pkg::angle_t            z_o
);
  import rav_pkg::*;

  // angle magnitude width and residual width
  localparam int MW = RAND_BITS + 16;
  localparam int RW = RAND_BITS + 13;

  localparam logic [RAND_BITS:0] MID = (RAND_BITS+1)'(1) << (RAND_BITS - 1);

  // quarter turn multiples and rounding thresholds
  localparam logic [MW-1:0] Q1  = MW'(11520) << RAND_BITS;
  localparam logic [MW-1:0] Q2  = MW'(23040) << RAND_BITS;
  localparam logic [MW-1:0] Q3  = MW'(34560) << RAND_BITS;
  localparam logic [MW-1:0] TH1 = MW'(5760) << RAND_BITS;
  localparam logic [MW-1:0] TH2 = MW'(17280) << RAND_BITS;
  localparam logic [MW-1:0] TH3 = MW'(28800) << RAND_BITS;
  localparam logic [RW-1:0] HALF_Q = RW'(5760) << RAND_BITS;

  // stage 1: signed deviation times span
  logic signed [RAND_BITS:0]   dev;
  logic [RAND_BITS-1:0]        dev_mag;
  logic [MW-1:0]               mag_nxt;
  logic                        v1_r;
  logic [MW-1:0]               mag_r;
  logic                        neg_r;
  logic signed [VEL_BITS-1:0]  x1_r, y1_r;

  always_comb begin
    dev     = $signed({1'b0, rand_u}) - $signed(MID);
    dev_mag = dev[RAND_BITS] ? RAND_BITS'(-dev) : RAND_BITS'(dev);
    mag_nxt = MW'(dev_mag) * MW'(span);
  end

  // stage 2: nearest quarter turn and residual
  logic [1:0]                  qm;
  logic [MW-1:0]               qq;
  logic signed [MW:0]          diff;
  logic signed [MW:0]          diff_abs;
  logic                        v2_r;
  logic [RW-1:0]               rm_r;
  logic                        rsgn2_r;
  logic [1:0]                  k2_r;
  logic signed [VEL_BITS-1:0]  x2_r, y2_r;

  always_comb begin
    if (mag_r >= TH3) begin
      qm = 2'd3;
    end else if (mag_r >= TH2) begin
      qm = 2'd2;
    end else if (mag_r >= TH1) begin
      qm = 2'd1;
    end else begin
      qm = 2'd0;
    end
    case (qm)
      2'd1:    qq = Q1;
      2'd2:    qq = Q2;
      2'd3:    qq = Q3;
      default: qq = '0;
    endcase
    diff     = $signed({1'b0, mag_r}) - $signed({1'b0, qq});
    diff_abs = diff[MW] ? -diff : diff;
  end

  // stage 3: residual times radian scale, four partial products
  logic [47:0]                 rm_ext;
  logic                        v3_r;
  logic [47:0]                 p00_r, p01_r, p10_r, p11_r;
  logic                        rsgn3_r;
  logic [1:0]                  k3_r;
  logic signed [VEL_BITS-1:0]  x3_r, y3_r;

  assign rm_ext = 48'(rm_r);

  // stage 4: sum, round, sign; quarter turns on the vector
  logic [95:0]                 prod_sum;
  logic [30:0]                 zmag;
  angle_t                      zm;
  angle_t                      z_nxt;
  logic signed [XW-1:0]        xe, ye;
  logic signed [XW-1:0]        xq_nxt, yq_nxt;
  logic                        v4_r;
  logic signed [XW-1:0]        x4_r, y4_r;
  angle_t                      z4_r;

  always_comb begin
    prod_sum = 96'(p00_r) + (96'(p01_r) << 24) + (96'(p10_r) << 24) + (96'(p11_r) << 48)
             + (96'(1) << (ANG_FRAC + RAND_BITS - 1));
    zmag     = 31'(prod_sum >> (ANG_FRAC + RAND_BITS));
    zm       = angle_t'({1'b0, zmag});
    z_nxt    = rsgn3_r ? -zm : zm;
    xe       = {{3{x3_r[VEL_BITS-1]}}, x3_r, {GUARD{1'b0}}};
    ye       = {{3{y3_r[VEL_BITS-1]}}, y3_r, {GUARD{1'b0}}};
    case (k3_r)
      2'd1: begin
        xq_nxt = -ye;
        yq_nxt = xe;
      end
      2'd2: begin
        xq_nxt = -xe;
        yq_nxt = -ye;
      end
      2'd3: begin
        xq_nxt = ye;
        yq_nxt = -xe;
      end
      default: begin
        xq_nxt = xe;
        yq_nxt = ye;
      end
    endcase
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      mag_r   <= mag_nxt;
      neg_r   <= dev[RAND_BITS];
      x1_r    <= vel_x;
      y1_r    <= vel_y;

      rm_r    <= diff_abs[RW-1:0];
      rsgn2_r <= diff[MW] ^ neg_r;
      k2_r    <= neg_r ? 2'(2'd0 - qm) : qm;
      x2_r    <= x1_r;
      y2_r    <= y1_r;

      p00_r   <= 48'(rm_ext[23:0])  * 48'(RAD_PER_UNIT[23:0]);
      p01_r   <= 48'(rm_ext[23:0])  * 48'(RAD_PER_UNIT[47:24]);
      p10_r   <= 48'(rm_ext[47:24]) * 48'(RAD_PER_UNIT[23:0]);
      p11_r   <= 48'(rm_ext[47:24]) * 48'(RAD_PER_UNIT[47:24]);
      rsgn3_r <= rsgn2_r;
      k3_r    <= k2_r;
      x3_r    <= x2_r;
      y3_r    <= y2_r;

      x4_r    <= xq_nxt;
      y4_r    <= yq_nxt;
      z4_r    <= z_nxt;
    end
  end

  assign out_valid = v4_r;
  assign x_o       = x4_r;
  assign y_o       = y4_r;
  assign z_o       = z4_r;

`ifndef SYNTHESIS
  a_residual_half_quarter: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (rm_r <= HALF_Q))
    else $error("residual angle exceeds half a quarter turn");

  a_angle_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> ((z4_r <= Z_MAX) && (z4_r >= -Z_MAX)))
    else $error("residual angle in radians out of range");
`endif

endmodule

[hdl/rav_cordic_stage.sv]
module rav_cordic_stage #(
  parameter int VEL_BITS = 24,
  parameter int SHIFT    = 0,
  localparam int XW = VEL_BITS + rav_pkg::GUARD + 3
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  rav_pkg::angle_t      z_i,
  output logic                 out_valid,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output rav_pkg::angle_t      z_o
);
  import rav_pkg::*;

  logic signed [XW-1:0] dx, dy;
  angle_t               step;
  logic                 v_r;
  logic signed [XW-1:0] x_r, y_r;
  angle_t               z_r;

  // shifted cross terms, floor rounding
  assign dx   = y_i >>> SHIFT;
  assign dy   = x_i >>> SHIFT;
  assign step = atan_q30(5'(SHIFT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  // rotate toward zero residual angle
  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_i[ZW-1]) begin
        x_r <= x_i - dx;
        y_r <= y_i + dy;
        z_r <= z_i - step;
      end else begin
        x_r <= x_i + dx;
        y_r <= y_i - dy;
        z_r <= z_i + step;
      end
    end
  end

  assign out_valid = v_r;
  assign x_o       = x_r;
  assign y_o       = y_r;
  assign z_o       = z_r;

endmodule

[hdl/rav_gain.sv]
module rav_gain #(
  parameter int VEL_BITS = 24,
  localparam int XW = VEL_BITS + rav_pkg::GUARD + 3
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic signed [XW-1:0]       x_i,
  input  logic signed [XW-1:0]       y_i,
  output logic                       out_valid,
  output logic signed [VEL_BITS-1:0] rot_x,
  output logic signed [VEL_BITS-1:0] rot_y
);
  import rav_pkg::*;

  localparam int PW = XW + 30;
  localparam int SH = 30 + GUARD;
  localparam int GW = PW - SH;

  logic signed [XW-1:0]       lane_in  [2];
  logic signed [VEL_BITS-1:0] lane_out [2];
  logic                       v1_r, v2_r, v3_r;

  assign lane_in[0] = x_i;
  assign lane_in[1] = y_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [XW-1:0]              mag1_r;
    logic                       s1_r;
    logic [PW-1:0]              prod2_r;
    logic                       s2_r;
    logic [PW-1:0]              rnd;
    logic [GW-1:0]              qmag;
    logic signed [GW:0]         sval;
    logic signed [VEL_BITS-1:0] sat_nxt;
    logic signed [VEL_BITS-1:0] out_r;

    // round magnitude ties up, restore sign, clamp to the velocity range
    always_comb begin
      rnd  = prod2_r + (PW'(1) << (SH - 1));
      qmag = GW'(rnd >> SH);
      sval = s2_r ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      if (sval[GW:VEL_BITS-1] == '0 || sval[GW:VEL_BITS-1] == '1) begin
        sat_nxt = sval[VEL_BITS-1:0];
      end else begin
        sat_nxt = sval[GW] ? {1'b1, {(VEL_BITS-1){1'b0}}} : {1'b0, {(VEL_BITS-1){1'b1}}};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s1_r    <= lane_in[l][XW-1];
        mag1_r  <= lane_in[l][XW-1] ? XW'(-lane_in[l]) : XW'(lane_in[l]);
        s2_r    <= s1_r;
        prod2_r <= PW'(mag1_r) * PW'(INV_K_Q30);
        out_r   <= sat_nxt;
      end
    end

    assign lane_out[l] = out_r;
  end

  assign out_valid = v3_r;
  assign rot_x     = lane_out[0];
  assign rot_y     = lane_out[1];

endmodule

[dv/rot_checker.sv]
module rot_checker #(
  parameter int         VEL_BITS      = 24,
  parameter int         RAND_BITS     = 16,
  parameter int         CORDIC_STAGES = 16,
  parameter logic [2:0] SPAN_ADDR     = 3'd0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic                       pready,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic signed [VEL_BITS-1:0] in_vel_x,
  input  logic signed [VEL_BITS-1:0] in_vel_y,
  input  logic [RAND_BITS-1:0]       in_rand_u,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic signed [VEL_BITS-1:0] out_rot_x,
  input  logic signed [VEL_BITS-1:0] out_rot_y,
  output int                         fail_count,
  output int                         rot_pending
);

  // extra fraction bits carried through the rotation, and the angle format
  localparam int FRAC_GUARD = 8;
  localparam int ANGLE_FRAC = 30;

  // pi in Q60, and radians per 1/128 degree scaled by 1/180
  localparam logic [63:0] PI_FIX60     = 64'h3243F6A8885A308D;
  localparam logic [63:0] RAD_PER_UNIT = PI_FIX60 / 64'd23040;
  localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;
  localparam logic [63:0] QUARTER_TURN = 64'd11520 << RAND_BITS;
  localparam longint      HALF_SCALE   = 64'sd1 <<< (RAND_BITS - 1);
  localparam longint      VEL_MAX      = (64'sd1 <<< (VEL_BITS - 1)) - 1;
  localparam longint      VEL_MIN      = -VEL_MAX - 1;

  // atan(2^-i) in Q30
  localparam longint ATAN_FIX30 [32] = '{
    843314857, 497837829, 263043837, 133525159,
    67021687, 33543516, 16775851, 8388437,
    4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048,
    1024, 512, 256, 128,
    64, 32, 16, 8,
    4, 2, 1, 0
  };

  typedef struct packed {
    logic signed [VEL_BITS-1:0] rot_x;
    logic signed [VEL_BITS-1:0] rot_y;
  } rot_vec_t;

  rot_vec_t    expected_rot_q[$];
  logic [15:0] span_q;

  // undo the CORDIC gain, drop the guard bits (ties away from zero), clip
  function automatic logic signed [VEL_BITS-1:0] gain_clip(input longint v);
    logic [63:0]  m;
    logic [127:0] p;
    longint       r;
    m = (v < 0) ? 64'(-v) : 64'(v);
    p = 128'(m) * 128'(INV_GAIN_Q30) + (128'd1 << (ANGLE_FRAC + FRAC_GUARD - 1));
    r = longint'(p >> (ANGLE_FRAC + FRAC_GUARD));
    if (v < 0) r = -r;
    if (r > VEL_MAX) r = VEL_MAX;
    else if (r < VEL_MIN) r = VEL_MIN;
    return r[VEL_BITS-1:0];
  endfunction

  // rotate one velocity by (u - 1/2) * span
  function automatic rot_vec_t rotate_noisy(input logic signed [VEL_BITS-1:0] vx,
                                            input logic signed [VEL_BITS-1:0] vy,
                                            input logic [RAND_BITS-1:0]       u,
                                            input logic [15:0]                span);
    longint       x, y, z, t, d, rem, dx, dy;
    logic [63:0]  mag, turns, rm;
    logic [127:0] p;
    int           k, i;
    rot_vec_t     res;
    x = longint'(vx) * (64'sd1 <<< FRAC_GUARD);
    y = longint'(vy) * (64'sd1 <<< FRAC_GUARD);
    d = longint'(u) - HALF_SCALE;

    // split into whole quarter turns (nearest, ties away from zero) and a rest
    mag   = 64'(d < 0 ? -d : d) * 64'(span);
    turns = (mag + QUARTER_TURN / 2) / QUARTER_TURN;
    rem   = longint'(mag) - longint'(turns * QUARTER_TURN);
    k     = int'(turns % 4);
    if (d < 0) begin
      rem = -rem;
      k   = (4 - k) % 4;
    end

    // rest to radians Q30, rounded half up on the magnitude
    rm = 64'(rem < 0 ? -rem : rem);
    p  = 128'(rm) * 128'(RAD_PER_UNIT) + (128'd1 << (ANGLE_FRAC + RAND_BITS - 1));
    z  = longint'(p >> (ANGLE_FRAC + RAND_BITS));
    if (rem < 0) z = -z;

    // exact quarter turns, counterclockwise
    repeat (k) begin
      t = x;
      x = -y;
      y = t;
    end

    // CORDIC stages; a zero residual steers positive
    for (i = 0; i < CORDIC_STAGES; i++) begin
      dx = y >>> (i & 31);
      dy = x >>> (i & 31);
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_FIX30[i & 31];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_FIX30[i & 31];
      end
    end

    res.rot_x = gain_clip(x);
    res.rot_y = gain_clip(y);
    return res;
  endfunction

  initial begin
    fail_count  = 0;
    rot_pending = 0;
    span_q      = '0;
  end

  // track the span register, queue predictions, compare each result transfer
  always @(posedge clk) begin : watch
    rot_vec_t want;
    if (!rst_n) begin
      span_q = '0;
      expected_rot_q.delete();
    end else begin
      if (in_valid && in_ready)
        expected_rot_q.push_back(rotate_noisy(in_vel_x, in_vel_y, in_rand_u, span_q));
      if (psel && penable && pwrite && pready && paddr == SPAN_ADDR)
        span_q = pwdata[15:0];
      if (out_valid && out_ready) begin
        if (expected_rot_q.size() == 0) begin
          $error("unexpected result transfer: rot_x %0d rot_y %0d", out_rot_x, out_rot_y);
          fail_count++;
        end else begin
          want = expected_rot_q.pop_front();
          if (out_rot_x !== want.rot_x) begin
            $error("rot_x: expected %0d, got %0d", want.rot_x, out_rot_x);
            fail_count++;
          end
          if (out_rot_y !== want.rot_y) begin
            $error("rot_y: expected %0d, got %0d", want.rot_y, out_rot_y);
            fail_count++;
          end
        end
      end
    end
    rot_pending = expected_rot_q.size();
  end

endmodule

[dv/tb_top.sv]
module tb_top;

  localparam int VEL_BITS      = 24;
  localparam int RAND_BITS     = 16;
  localparam int CORDIC_STAGES = 16;

  localparam logic [2:0]  NOISE_SPAN_ADDR = 3'd0;
  localparam logic [15:0] SPAN_FULL_TURN  = 16'd46080;
  localparam int          DRAIN_CYCLES    = CORDIC_STAGES + 7 + 10;
  localparam int          PHASES          = 6;
  localparam int          PHASE_ITEMS     = 125;

  localparam logic signed [VEL_BITS-1:0] V_MAX = {1'b0, {(VEL_BITS-1){1'b1}}};
  localparam logic signed [VEL_BITS-1:0] V_MIN = {1'b1, {(VEL_BITS-1){1'b0}}};
  localparam logic [RAND_BITS-1:0]       U_HALF = 1 << (RAND_BITS - 1);

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       psel, penable, pwrite, pready;
  logic [2:0]                 paddr;
  logic [31:0]                pwdata, prdata;
  logic                       in_valid, in_ready;
  logic signed [VEL_BITS-1:0] in_vel_x, in_vel_y;
  logic [RAND_BITS-1:0]       in_rand_u;
  logic                       out_valid, out_ready;
  logic signed [VEL_BITS-1:0] out_rot_x, out_rot_y;
  int                         fail_count, rot_pending;
  int                         idle_pct, stall_pct;

  random_angle_vector_rotation_2d #(
    .VEL_BITS     (VEL_BITS),
    .RAND_BITS    (RAND_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_vel_x (in_vel_x),
    .in_vel_y (in_vel_y),
    .in_rand_u(in_rand_u),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_rot_x(out_rot_x),
    .out_rot_y(out_rot_y)
  );

  rot_checker #(
    .VEL_BITS     (VEL_BITS),
    .RAND_BITS    (RAND_BITS),
    .CORDIC_STAGES(CORDIC_STAGES),
    .SPAN_ADDR    (NOISE_SPAN_ADDR)
  ) u_rot_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_vel_x   (in_vel_x),
    .in_vel_y   (in_vel_y),
    .in_rand_u  (in_rand_u),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rot_x  (out_rot_x),
    .out_rot_y  (out_rot_y),
    .fail_count (fail_count),
    .rot_pending(rot_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: stall at random
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // hold until every expected result has come back
  task automatic wait_drained;
    while (rot_pending != 0) @(negedge clk);
  endtask

  // register write with a setup and an access phase; upper data bits are random filler
  task automatic write_span(input logic [15:0] span);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NOISE_SPAN_ADDR;
    pwdata  <= {16'($urandom), span};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // idle at random, then hold the item until its transfer
  task automatic send_vector(input logic signed [VEL_BITS-1:0] vx,
                             input logic signed [VEL_BITS-1:0] vy,
                             input logic [RAND_BITS-1:0]       u);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_vel_x  <= vx;
    in_vel_y  <= vy;
    in_rand_u <= u;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic signed [VEL_BITS-1:0] pick_vel();
    case ($urandom_range(7))
      0:       return V_MAX;
      1:       return V_MIN;
      2:       return VEL_BITS'($urandom_range(511)) - VEL_BITS'(256);
      default: return VEL_BITS'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [VEL_BITS-1:0] vx, vy;
    logic [RAND_BITS-1:0]       u;
    logic [15:0]                span;
    rst_n     = 1'b0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    in_vel_x  = '0;
    in_vel_y  = '0;
    in_rand_u = '0;
    out_ready = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners: span at reset value, a full turn, then the register maximum
    for (int s = 0; s < 3; s++) begin
      if (s > 0) begin
        in_valid <= 1'b0;
        wait_drained();
        write_span(s == 1 ? SPAN_FULL_TURN : 16'hFFFF);
      end
      for (int i = 0; i < 8; i++) begin
        case (i)
          0: begin vx = V_MAX; vy = V_MAX; u = U_HALF; end
          1: begin vx = V_MAX; vy = V_MAX; u = U_HALF + U_HALF / 4; end
          2: begin vx = V_MIN; vy = V_MIN; u = '0; end
          3: begin vx = V_MIN; vy = V_MAX; u = '1; end
          4: begin vx = V_MAX; vy = V_MIN; u = U_HALF - U_HALF / 4; end
          5: begin vx = 1; vy = -1; u = U_HALF / 2; end
          6: begin vx = V_MIN; vy = '0; u = U_HALF + U_HALF / 2; end
          default: begin vx = '0; vy = '0; u = RAND_BITS'($urandom); end
        endcase
        send_vector(vx, vy, u);
      end
    end

    // random phases, each with its own span; idle and stall profiles cycle through four settings
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      wait_drained();
      case (p)
        0:       span = SPAN_FULL_TURN;
        1:       span = 16'($urandom_range(SPAN_FULL_TURN));
        2:       span = '0;
        3:       span = 16'hFFFF;
        4:       span = 16'($urandom_range(SPAN_FULL_TURN - 1, 1));
        default: span = 16'd1;
      endcase
      write_span(span);
      case (p % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 67; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // pause the sender mid-phase until the pipeline is empty
        if (i == PHASE_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait_drained();
        end
        case ($urandom_range(9))
          0:       u = '0;
          1:       u = '1;
          2:       u = U_HALF;
          3:       u = U_HALF + U_HALF / 4;
          4:       u = U_HALF - U_HALF / 4;
          default: u = RAND_BITS'($urandom);
        endcase
        send_vector(pick_vel(), pick_vel(), u);
      end
    end

    // finish: drain, then let stray results show up
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  // hard stop if a handshake never completes
  initial begin
    #2000000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

[random_angle_vector_rotation_2d.f]
hdl/rav_pkg.sv
hdl/rav_prep.sv
hdl/rav_cordic_stage.sv
hdl/rav_gain.sv
hdl/random_angle_vector_rotation_2d.sv
dv/rot_checker.sv
dv/tb_top.sv
